>>> hdl/imh_pkg.sv
// Package for the indexed min-heap core: request and status codes, controller states, command and status structs.
// No dependencies.
package imh_pkg;
  localparam int NodeCountDefault = 1024;
  localparam int CostBitsDefault  = 32;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_SPARE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_LOWERED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTYPOP = 3'd4,
    ST_QUERY    = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_POSW, S_PCHK, S_LRW, S_LCMP,
    S_POPRW, S_POPLW, S_POPW, S_POPFIX,
    S_UPCHK, S_UPRW, S_UPCMP,
    S_DNCHK, S_DNRW, S_DNRRW, S_DNPICK, S_DNCMP,
    S_SWAP, S_SWAP2, S_TOP, S_TOPW, S_DONE
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic    clr_step;    // write absent at clear address, advance
    logic    lat_req;     // latch request fields
    logic    rd_pos;      // read position of requested id
    logic    rd_root;     // read slot 1
    logic    rd_last;     // read slot at count
    logic    rd_pos_slot; // read slot at latched position
    logic    rd_parent;   // read slot cur/2, other = cur/2
    logic    rd_left;     // read slot cur*2, other = cur*2
    logic    rd_right;    // read slot other+1
    logic    lat_pos;
    logic    lat_a;
    logic    lat_b;
    logic    lat_c;
    logic    do_insert;   // write new entry at count+1, count++
    logic    do_lower;    // write lowered cost at position
    logic    do_pop;      // mark root id absent, move last to root, count--
    logic    pop_fix;     // moved entry now sits at the root
    logic    pick_right;  // best child is the right one
    logic    swap_a;      // place cur entry at other
    logic    swap_b;      // place other entry at cur, cur = other
    logic    lat_top;
    status_e status;
    logic    set_status;
    logic    done;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic id_ok;
    logic pos_zero;
    logic lower_ok;
    logic full;
    logic empty;
    logic at_root;
    logic parent_gt;   // parent cost > child cost
    logic has_left;
    logic has_right;
    logic right_better;
    logic best_better; // chosen child less than cur
  } stat_t;
endpackage

>>> hdl/imh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module imh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write or read one address per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> hdl/imh_datapath.sv
// Datapath of the min-heap core: slot and position memories, pointers, comparators.
// Depends on imh_pkg and imh_ram.
module imh_datapath #(
  parameter int NodeCount = imh_pkg::NodeCountDefault,
  parameter int CostBits  = imh_pkg::CostBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imh_pkg::cmd_t     cmd_i,
  output imh_pkg::stat_t    stat_o,
  input  logic [9:0]        node_id_i,
  input  logic [31:0]       cost_i,
  output logic [31:0]       top_cost_o,
  output logic [9:0]        top_id_o,
  output logic              is_empty_o,
  output logic [10:0]       entry_count_o,
  output logic [2:0]        status_o,
  output logic              done_o
);
  localparam int SlotDepth = NodeCount + 1;
  localparam int SlotBits  = $clog2(SlotDepth);
  localparam int IdBits    = $clog2(NodeCount);
  localparam int EntBits   = CostBits + 10;

  logic [SlotBits-1:0] cur_q, other_q, count_q, clr_q, pos_q;
  logic [CostBits-1:0] req_cost_q, a_cost_q, b_cost_q, c_cost_q;
  logic [9:0]          req_id_q, a_id_q, b_id_q, c_id_q;
  logic [2:0]          status_q;
  logic                done_q;
  logic [31:0]         top_cost_q;
  logic [9:0]          top_id_q;

  // Slot and position RAM ports
  logic                slot_we, pos_we;
  logic [SlotBits-1:0] slot_addr, pos_wdata;
  logic [EntBits-1:0]  slot_wdata, slot_rdata;
  logic [IdBits-1:0]   pos_addr;
  logic [SlotBits-1:0] pos_rdata;
  logic [CostBits-1:0] rd_cost;
  logic [9:0]          rd_id;
  assign rd_cost = slot_rdata[EntBits-1:10];
  assign rd_id   = slot_rdata[9:0];

  imh_ram #(.Width(EntBits), .Depth(SlotDepth)) u_slot (
    .clk_i, .we_i(slot_we), .addr_i(slot_addr), .wdata_i(slot_wdata), .rdata_o(slot_rdata));
  imh_ram #(.Width(SlotBits), .Depth(NodeCount)) u_pos (
    .clk_i, .we_i(pos_we), .addr_i(pos_addr), .wdata_i(pos_wdata), .rdata_o(pos_rdata));

  logic [SlotBits-1:0] nxt_slot;
  assign nxt_slot = count_q + SlotBits'(1);

  // Memory address and write selection
  always_comb begin
    slot_we = 1'b0; slot_addr = cur_q; slot_wdata = {a_cost_q, a_id_q};
    pos_we = 1'b0; pos_addr = IdBits'(req_id_q); pos_wdata = '0;
    if (cmd_i.clr_step) begin
      pos_we = 1'b1; pos_addr = IdBits'(clr_q);
    end else if (cmd_i.rd_pos) begin
      pos_addr = IdBits'(req_id_q);
    end else if (cmd_i.rd_root) begin
      slot_addr = SlotBits'(1);
    end else if (cmd_i.rd_last) begin
      slot_addr = count_q;
    end else if (cmd_i.rd_pos_slot) begin
      slot_addr = pos_q;
    end else if (cmd_i.rd_parent) begin
      slot_addr = cur_q >> 1;
    end else if (cmd_i.rd_left) begin
      slot_addr = {cur_q[SlotBits-2:0], 1'b0};
    end else if (cmd_i.rd_right) begin
      slot_addr = other_q + SlotBits'(1);
    end else if (cmd_i.do_insert) begin
      slot_we = 1'b1; slot_addr = nxt_slot; slot_wdata = {req_cost_q, req_id_q};
      pos_we = 1'b1; pos_addr = IdBits'(req_id_q); pos_wdata = nxt_slot;
    end else if (cmd_i.do_lower) begin
      slot_we = 1'b1; slot_addr = pos_q; slot_wdata = {req_cost_q, req_id_q};
    end else if (cmd_i.do_pop) begin
      // a holds root, b holds last entry
      slot_we = 1'b1; slot_addr = SlotBits'(1); slot_wdata = {b_cost_q, b_id_q};
      pos_we = 1'b1; pos_addr = IdBits'(a_id_q); pos_wdata = '0;
    end else if (cmd_i.pop_fix) begin
      // last entry now at root, only when something is still held
      pos_we = (count_q != '0); pos_addr = IdBits'(b_id_q);
      pos_wdata = SlotBits'(1);
    end else if (cmd_i.swap_a) begin
      // place a (cur entry) at other
      slot_we = 1'b1; slot_addr = other_q; slot_wdata = {a_cost_q, a_id_q};
      pos_we = 1'b1; pos_addr = IdBits'(a_id_q); pos_wdata = other_q;
    end else if (cmd_i.swap_b) begin
      // place b (other entry) at cur
      slot_we = 1'b1; slot_addr = cur_q; slot_wdata = {b_cost_q, b_id_q};
      pos_we = 1'b1; pos_addr = IdBits'(b_id_q); pos_wdata = cur_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; clr_q <= '0; done_q <= 1'b0; status_q <= '0;
    end else begin
      done_q <= cmd_i.done;
      if (cmd_i.clr_step) clr_q <= clr_q + SlotBits'(1);
      if (cmd_i.do_insert) count_q <= nxt_slot;
      else if (cmd_i.do_pop) count_q <= count_q - SlotBits'(1);
      if (cmd_i.set_status) status_q <= cmd_i.status;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_req) begin
      req_id_q <= node_id_i;
      req_cost_q <= CostBits'(cost_i);
    end
    if (cmd_i.lat_pos) pos_q <= pos_rdata;
    if (cmd_i.lat_a) begin
      a_cost_q <= rd_cost; a_id_q <= rd_id;
    end else if (cmd_i.do_insert || cmd_i.do_lower) begin
      a_cost_q <= req_cost_q; a_id_q <= req_id_q;
    end else if (cmd_i.do_pop) begin
      a_cost_q <= b_cost_q; a_id_q <= b_id_q;
    end
    if (cmd_i.lat_b) begin
      b_cost_q <= rd_cost; b_id_q <= rd_id;
    end else if (cmd_i.pick_right) begin
      b_cost_q <= c_cost_q; b_id_q <= c_id_q;
    end
    if (cmd_i.lat_c) begin
      c_cost_q <= rd_cost; c_id_q <= rd_id;
    end
    if (cmd_i.do_insert) cur_q <= nxt_slot;
    else if (cmd_i.do_lower) cur_q <= pos_q;
    else if (cmd_i.do_pop) cur_q <= SlotBits'(1);
    else if (cmd_i.swap_b) cur_q <= other_q;
    if (cmd_i.rd_parent) other_q <= cur_q >> 1;
    else if (cmd_i.rd_left) other_q <= {cur_q[SlotBits-2:0], 1'b0};
    else if (cmd_i.pick_right) other_q <= other_q + SlotBits'(1);
    if (cmd_i.lat_top) begin
      top_cost_q <= (count_q == '0) ? '0 : 32'(rd_cost);
      top_id_q   <= (count_q == '0) ? '0 : rd_id;
    end
  end

  // Status toward the controller
  logic [SlotBits:0] left_w;
  assign left_w = {cur_q, 1'b0};
  always_comb begin
    stat_o.clr_done   = (clr_q == SlotBits'(NodeCount - 1));
    stat_o.id_ok      = ({22'd0, req_id_q} < 32'(NodeCount));
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.lower_ok   = (req_cost_q < a_cost_q);
    stat_o.full       = (32'(count_q) >= 32'(NodeCount));
    stat_o.empty      = (count_q == '0);
    stat_o.at_root    = (cur_q <= SlotBits'(1));
    stat_o.parent_gt  = (b_cost_q > a_cost_q);
    stat_o.has_left   = (left_w <= {1'b0, count_q});
    stat_o.has_right  = (left_w + (SlotBits+1)'(1) <= {1'b0, count_q});
    stat_o.right_better = (c_cost_q < b_cost_q) ||
                          (c_cost_q == b_cost_q && c_id_q < b_id_q);
    stat_o.best_better = (b_cost_q < a_cost_q) ||
                         (b_cost_q == a_cost_q && b_id_q < a_id_q);
  end

  assign top_cost_o    = top_cost_q;
  assign top_id_o      = top_id_q;
  assign is_empty_o    = (count_q == '0);
  assign entry_count_o = 11'(count_q);
  assign status_o      = status_q;
  assign done_o        = done_q;
endmodule

>>> hdl/imh_ctrl.sv
// Controller state machine of the min-heap core.
// Depends on imh_pkg.
module imh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     req_type_i,
  input  imh_pkg::stat_t stat_i,
  output imh_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  imh_pkg::state_e state_q, state_d;
  imh_pkg::req_e   req_q;
  logic            sink_q;

  // Hold request kind and sift direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imh_pkg::S_CLEAR; req_q <= imh_pkg::REQ_QUERY; sink_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == imh_pkg::S_IDLE && start_i) begin
        req_q <= imh_pkg::req_e'(req_type_i);
        sink_q <= 1'b0;
      end else if (state_q == imh_pkg::S_POPW) begin
        sink_q <= 1'b1;
      end
    end
  end

  assign busy_o = (state_q != imh_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      imh_pkg::S_CLEAR: if (stat_i.clr_done) state_d = imh_pkg::S_IDLE;
      imh_pkg::S_IDLE:  if (start_i) state_d = imh_pkg::S_DEC;
      imh_pkg::S_DEC: begin
        case (req_q)
          imh_pkg::REQ_PUSH: state_d = stat_i.id_ok ? imh_pkg::S_POSW : imh_pkg::S_TOP;
          imh_pkg::REQ_POP:  state_d = stat_i.empty ? imh_pkg::S_TOP : imh_pkg::S_POPRW;
          default:           state_d = imh_pkg::S_TOP;
        endcase
      end
      imh_pkg::S_POSW: state_d = imh_pkg::S_PCHK;
      imh_pkg::S_PCHK: begin
        if (!stat_i.pos_zero) state_d = imh_pkg::S_LRW;
        else if (stat_i.full) state_d = imh_pkg::S_TOP;
        else state_d = imh_pkg::S_UPCHK;
      end
      imh_pkg::S_LRW:    state_d = imh_pkg::S_LCMP;
      imh_pkg::S_LCMP:   state_d = stat_i.lower_ok ? imh_pkg::S_UPCHK : imh_pkg::S_TOP;
      imh_pkg::S_POPRW:  state_d = imh_pkg::S_POPLW;
      imh_pkg::S_POPLW:  state_d = imh_pkg::S_POPW;
      imh_pkg::S_POPW:   state_d = imh_pkg::S_POPFIX;
      imh_pkg::S_POPFIX: state_d = imh_pkg::S_DNCHK;
      imh_pkg::S_UPCHK:  state_d = stat_i.at_root ? imh_pkg::S_TOP : imh_pkg::S_UPRW;
      imh_pkg::S_UPRW:   state_d = imh_pkg::S_UPCMP;
      imh_pkg::S_UPCMP:  state_d = stat_i.parent_gt ? imh_pkg::S_SWAP : imh_pkg::S_TOP;
      imh_pkg::S_DNCHK:  state_d = stat_i.has_left ? imh_pkg::S_DNRW : imh_pkg::S_TOP;
      imh_pkg::S_DNRW:   state_d = stat_i.has_right ? imh_pkg::S_DNRRW : imh_pkg::S_DNCMP;
      imh_pkg::S_DNRRW:  state_d = imh_pkg::S_DNPICK;
      imh_pkg::S_DNPICK: state_d = imh_pkg::S_DNCMP;
      imh_pkg::S_DNCMP:  state_d = stat_i.best_better ? imh_pkg::S_SWAP : imh_pkg::S_TOP;
      imh_pkg::S_SWAP:   state_d = imh_pkg::S_SWAP2;
      imh_pkg::S_SWAP2:  state_d = sink_q ? imh_pkg::S_DNCHK : imh_pkg::S_UPCHK;
      imh_pkg::S_TOP:    state_d = imh_pkg::S_TOPW;
      imh_pkg::S_TOPW:   state_d = imh_pkg::S_DONE;
      imh_pkg::S_DONE:   state_d = imh_pkg::S_IDLE;
      default:           state_d = imh_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      imh_pkg::S_CLEAR: cmd_o.clr_step = 1'b1;
      imh_pkg::S_IDLE:  cmd_o.lat_req = start_i;
      imh_pkg::S_DEC: begin
        case (req_q)
          imh_pkg::REQ_PUSH: begin
            if (stat_i.id_ok) cmd_o.rd_pos = 1'b1;
            else begin
              cmd_o.set_status = 1'b1; cmd_o.status = imh_pkg::ST_IGNORED;
            end
          end
          imh_pkg::REQ_POP: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1; cmd_o.status = imh_pkg::ST_EMPTYPOP;
            end else cmd_o.rd_root = 1'b1;
          end
          default: begin
            cmd_o.set_status = 1'b1; cmd_o.status = imh_pkg::ST_QUERY;
          end
        endcase
      end
      imh_pkg::S_POSW: cmd_o.lat_pos = 1'b1;
      imh_pkg::S_PCHK: begin
        if (!stat_i.pos_zero) cmd_o.rd_pos_slot = 1'b1;
        else if (stat_i.full) begin
          cmd_o.set_status = 1'b1; cmd_o.status = imh_pkg::ST_IGNORED;
        end else begin
          cmd_o.do_insert = 1'b1;
          cmd_o.set_status = 1'b1; cmd_o.status = imh_pkg::ST_INSERTED;
        end
      end
      imh_pkg::S_LRW: cmd_o.lat_a = 1'b1;
      imh_pkg::S_LCMP: begin
        cmd_o.set_status = 1'b1;
        if (stat_i.lower_ok) begin
          cmd_o.do_lower = 1'b1; cmd_o.status = imh_pkg::ST_LOWERED;
        end else cmd_o.status = imh_pkg::ST_IGNORED;
      end
      imh_pkg::S_POPRW: begin
        cmd_o.lat_a = 1'b1; cmd_o.rd_last = 1'b1;
      end
      imh_pkg::S_POPLW: cmd_o.lat_b = 1'b1;
      imh_pkg::S_POPW: begin
        cmd_o.do_pop = 1'b1; cmd_o.set_status = 1'b1;
        cmd_o.status = imh_pkg::ST_POPPED;
      end
      imh_pkg::S_POPFIX: cmd_o.pop_fix = 1'b1;
      imh_pkg::S_UPCHK:  cmd_o.rd_parent = !stat_i.at_root;
      imh_pkg::S_UPRW:   cmd_o.lat_b = 1'b1;
      imh_pkg::S_DNCHK:  cmd_o.rd_left = stat_i.has_left;
      imh_pkg::S_DNRW: begin
        cmd_o.lat_b = 1'b1; cmd_o.rd_right = stat_i.has_right;
      end
      imh_pkg::S_DNRRW:  cmd_o.lat_c = 1'b1;
      imh_pkg::S_DNPICK: cmd_o.pick_right = stat_i.right_better;
      imh_pkg::S_SWAP:   cmd_o.swap_a = 1'b1;
      imh_pkg::S_SWAP2:  cmd_o.swap_b = 1'b1;
      imh_pkg::S_TOP:    cmd_o.rd_root = 1'b1;
      imh_pkg::S_TOPW:   cmd_o.lat_top = 1'b1;
      imh_pkg::S_DONE:   cmd_o.done = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> hdl/indexed_min_heap_decrease_key_core.sv
// Top level of the indexed min-heap core with decrease-key.
// Depends on imh_pkg, imh_ctrl, imh_datapath, imh_ram.
//
// channel   | signals                                   | handshake
// request   | req_type_i node_id_i cost_i               | start_i high, busy_o low
// result    | top_cost_o top_id_o is_empty_o            | done_o strobe, one cycle
//           | entry_count_o status_o                    |
//
// busy_o stays high for the whole of a request, longer for each level climbed or
// descended; the single-port slot memory, one read or write a cycle, sets this.
// The result follows in the first cycle with busy_o low. After reset the position
// memory is cleared with busy_o high. The result strobe cannot be stalled.
module indexed_min_heap_decrease_key_core #(
  parameter int NODE_COUNT = imh_pkg::NodeCountDefault,
  parameter int COST_BITS  = imh_pkg::CostBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  node_id_i,
  input  logic [31:0] cost_i,
  output logic        done_o,
  output logic [31:0] top_cost_o,
  output logic [9:0]  top_id_o,
  output logic        is_empty_o,
  output logic [10:0] entry_count_o,
  output logic [2:0]  status_o
);
  imh_pkg::cmd_t  cmd;
  imh_pkg::stat_t stat;

  imh_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .req_type_i, .stat_i(stat), .cmd_o(cmd), .busy_o);

  imh_datapath #(.NodeCount(NODE_COUNT), .CostBits(COST_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .node_id_i, .cost_i,
    .top_cost_o, .top_id_o, .is_empty_o, .entry_count_o, .status_o, .done_o);

  // No result strobe right after an accepted request
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(start_i && !busy_o)) else $error("result while accepting");
  // Empty flag tracks the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_empty_o == (entry_count_o == 11'd0)) else $error("empty flag mismatch");
  // Count never exceeds capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(entry_count_o) <= 32'(NODE_COUNT)) else $error("count overflow");
endmodule

>>> verif/imh_checker.sv
// Result checker for the indexed min-heap core: tracks heap contents per request.
// Depends on imh_pkg; instantiated beside the core by tb_indexed_min_heap_decrease_key_core.
module imh_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  node_id_i,
  input  logic [31:0] cost_i,
  input  logic        done_i,
  input  logic [31:0] top_cost_i,
  input  logic [9:0]  top_id_i,
  input  logic        is_empty_i,
  input  logic [10:0] entry_count_i,
  input  logic [2:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int Nodes = imh_pkg::NodeCountDefault;

  typedef struct packed {
    logic [31:0] top_cost;
    logic [9:0]  top_id;
    logic        is_empty;
    logic [10:0] entry_count;
    logic [2:0]  status;
  } heap_view_t;

  logic [31:0] h_cost [1:Nodes];
  logic [9:0]  h_id   [1:Nodes];
  int          slot_of [Nodes];
  int          held;
  heap_view_t  view_q [$];

  function automatic bit entry_lt(int a, int b);
    if (h_cost[a] != h_cost[b]) return h_cost[a] < h_cost[b];
    return h_id[a] < h_id[b];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] c;
    logic [9:0]  i;
    c = h_cost[a]; i = h_id[a];
    h_cost[a] = h_cost[b]; h_id[a] = h_id[b];
    h_cost[b] = c; h_id[b] = i;
    slot_of[h_id[a]] = a;
    slot_of[h_id[b]] = b;
  endfunction

  function automatic void sift_up(int at);
    while (at > 1 && h_cost[at / 2] > h_cost[at]) begin
      swap_slots(at / 2, at);
      at = at / 2;
    end
  endfunction

  function automatic void sift_down(int at);
    int best;
    while (2 * at <= held) begin
      best = at;
      if (entry_lt(2 * at, best)) best = 2 * at;
      if (2 * at + 1 <= held && entry_lt(2 * at + 1, best)) best = 2 * at + 1;
      if (best == at) return;
      swap_slots(at, best);
      at = best;
    end
  endfunction

  // Apply one request to the shadow heap and return the view afterwards
  function automatic heap_view_t apply_request(imh_pkg::req_e req, logic [9:0] id,
                                               logic [31:0] cost);
    heap_view_t v;
    imh_pkg::status_e st;
    int p;
    if (req == imh_pkg::REQ_PUSH) begin
      p = (int'(id) < Nodes) ? slot_of[id] : 0;
      if (int'(id) >= Nodes) st = imh_pkg::ST_IGNORED;
      else if (p != 0) begin
        if (cost < h_cost[p]) begin
          h_cost[p] = cost;
          sift_up(p);
          st = imh_pkg::ST_LOWERED;
        end else st = imh_pkg::ST_IGNORED;
      end else if (held >= Nodes) st = imh_pkg::ST_IGNORED;
      else begin
        held++;
        h_cost[held] = cost; h_id[held] = id;
        slot_of[id] = held;
        sift_up(held);
        st = imh_pkg::ST_INSERTED;
      end
    end else if (req == imh_pkg::REQ_POP) begin
      if (held == 0) st = imh_pkg::ST_EMPTYPOP;
      else begin
        slot_of[h_id[1]] = 0;
        if (held > 1) begin
          h_cost[1] = h_cost[held]; h_id[1] = h_id[held];
          slot_of[h_id[1]] = 1;
        end
        held--;
        sift_down(1);
        st = imh_pkg::ST_POPPED;
      end
    end else st = imh_pkg::ST_QUERY;
    v.top_cost    = (held == 0) ? '0 : h_cost[1];
    v.top_id      = (held == 0) ? '0 : h_id[1];
    v.is_empty    = (held == 0);
    v.entry_count = 11'(held);
    v.status      = st;
    return v;
  endfunction

  // Predict on accepted requests, compare on result strobes
  always @(posedge clk_i or negedge rst_ni) begin
    heap_view_t got, want;
    if (!rst_ni) begin
      held = 0;
      foreach (slot_of[k]) slot_of[k] = 0;
      view_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        got = {top_cost_i, top_id_i, is_empty_i, entry_count_i, status_i};
        if (view_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = view_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) $display("result mismatch: exp %p got %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        view_q.push_back(apply_request(imh_pkg::req_e'(req_type_i), node_id_i, cost_i));
      pending_o <= view_q.size();
    end
  end
endmodule

>>> verif/tb_indexed_min_heap_decrease_key_core.sv
// Testbench top for the indexed min-heap core: clock, reset, request stimulus, verdict.
// Depends on imh_pkg, imh_checker and the core.
module tb_indexed_min_heap_decrease_key_core;
  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = imh_pkg::REQ_QUERY;
  logic [9:0]  node_id_i = '0;
  logic [31:0] cost_i = '0;
  logic        done_o;
  logic [31:0] top_cost_o;
  logic [9:0]  top_id_o;
  logic        is_empty_o;
  logic [10:0] entry_count_o;
  logic [2:0]  status_o;
  int          fail_count, pending, idle_cycles, gap_pct;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  indexed_min_heap_decrease_key_core i_dut (.*);

  imh_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i, .node_id_i, .cost_i,
    .done_i(done_o), .top_cost_i(top_cost_o), .top_id_i(top_id_o),
    .is_empty_i(is_empty_o), .entry_count_i(entry_count_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: count cycles without an accepted request or result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit + 2 * imh_pkg::NodeCountDefault) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one request, with a random sender gap first; start stays high until
  // the next request or gap replaces it
  task automatic send_request(imh_pkg::req_e req, logic [9:0] id, logic [31:0] cost);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_type_i <= req;
    node_id_i <= id;
    cost_i <= cost;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Random request: mostly pushes from a given id pool, some pops, queries and spare codes
  task automatic random_request(int pool);
    int r;
    logic [31:0] c;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = $urandom_range(15);
      default: c = $urandom_range(4000);
    endcase
    if (r < 55) send_request(imh_pkg::REQ_PUSH, 10'($urandom_range(pool - 1)), c);
    else if (r < 62) send_request(imh_pkg::REQ_PUSH, 10'($urandom), c);
    else if (r < 92) send_request(imh_pkg::REQ_POP, 10'($urandom), $urandom);
    else if (r < 96) send_request(imh_pkg::REQ_QUERY, 10'($urandom), $urandom);
    else send_request(imh_pkg::REQ_SPARE, 10'($urandom), $urandom);
  endtask

  initial begin
    gap_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, extremes, equal cost, decrease, spare code, drain
    send_request(imh_pkg::REQ_POP, 10'd0, 32'd0);
    send_request(imh_pkg::REQ_QUERY, 10'h3FF, 32'hFFFF_FFFF);
    send_request(imh_pkg::REQ_PUSH, 10'h3FF, 32'hFFFF_FFFF);
    send_request(imh_pkg::REQ_PUSH, 10'd0, 32'hFFFF_FFFF);
    send_request(imh_pkg::REQ_PUSH, 10'h155, 32'h5555_5555);
    send_request(imh_pkg::REQ_PUSH, 10'h2AA, 32'hAAAA_AAAA);
    send_request(imh_pkg::REQ_PUSH, 10'h2AA, 32'hAAAA_AAAA);
    send_request(imh_pkg::REQ_PUSH, 10'h2AA, 32'hFFFF_FFFF);
    send_request(imh_pkg::REQ_PUSH, 10'h3FF, 32'd0);
    send_request(imh_pkg::REQ_PUSH, 10'd7, 32'd0);
    send_request(imh_pkg::REQ_PUSH, 10'd0, 32'h0000_0001);
    send_request(imh_pkg::REQ_SPARE, 10'd3, 32'd3);
    repeat (7) send_request(imh_pkg::REQ_POP, 10'd0, 32'd0);
    send_request(imh_pkg::REQ_PUSH, 10'h155, 32'd9);
    send_request(imh_pkg::REQ_POP, 10'd0, 32'd0);
    send_request(imh_pkg::REQ_POP, 10'd0, 32'd0);

    // Random phases with different sender idling
    gap_pct = 21;
    repeat (170) random_request(($urandom_range(1)) ? 24 : 1024);
    gap_pct = 63;
    repeat (170) random_request(($urandom_range(1)) ? 12 : 1024);
    gap_pct = 0;
    repeat (160) random_request(($urandom_range(1)) ? 40 : 1024);
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
